@@ rtl/core/sptw_pkg.sv @@
`default_nettype none

package sptw_pkg;

    localparam int INDEX_BITS     = 12;
    localparam int ANGLE_BITS     = 32;
    localparam int TRIG_FRAC_BITS = 16;

    localparam int IDX_W     = 12;
    localparam int RANGE_W   = 16;
    localparam int ANGLE_W   = 32;
    localparam int OFF_W     = 17;
    localparam int OUT_W     = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [IDX_W-1:0]          t_index;
    typedef logic [RANGE_W-1:0]        t_range;
    typedef logic [ANGLE_W-1:0]        t_angle;
    typedef logic signed [OFF_W-1:0]   t_off;
    typedef logic signed [OUT_W-1:0]   t_coord;
    typedef logic [29:0]               t_q30;
    typedef logic [30:0]               t_q30e;
    typedef logic [7:0]                t_coef;
    typedef logic [TRIG_FRAC_BITS:0]   t_mag;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]     t_cfg_data;

    // Octant information of the folded angle.
    typedef struct packed {
        logic [1:0] quad;
        logic       low_half;
    } t_oct;

    // Sine and cosine as magnitude and sign.
    typedef struct packed {
        t_mag sin_mag;
        logic sin_neg;
        t_mag cos_mag;
        logic cos_neg;
    } t_trig;

    localparam t_cfg_idx CFG_STEP_ANGLE     = 3'd0;
    localparam t_cfg_idx CFG_START_ANGLE    = 3'd1;
    localparam t_cfg_idx CFG_MOUNT_ROTATION = 3'd2;
    localparam t_cfg_idx CFG_MOUNT_OFFSET_X = 3'd3;
    localparam t_cfg_idx CFG_MOUNT_OFFSET_Y = 3'd4;

    localparam t_index IDX_MASK   = t_index'((64'd1 << INDEX_BITS) - 64'd1);
    localparam t_angle ANGLE_KEEP = ~t_angle'((64'd1 << (ANGLE_W - ANGLE_BITS)) - 64'd1);

    localparam t_q30e       Q30_ONE  = 31'h4000_0000;
    localparam t_q30        OCT_HALF = 30'h2000_0000;
    localparam logic [30:0] PI4_Q31  = 31'd1686629713;

    localparam int STEP_LAT  = 4;
    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;

    localparam t_coef SIN_K [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam t_coef COS_K [COS_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

endpackage

`default_nettype wire

@@ rtl/core/sptw_angle.sv @@
`default_nettype none

module sptw_angle (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  sptw_pkg::t_index i_beam_index,
    input  sptw_pkg::t_range i_range_mm,
    input  sptw_pkg::t_angle i_step_angle,
    input  sptw_pkg::t_angle i_start_angle,
    input  sptw_pkg::t_angle i_mount_rotation,
    output logic             o_valid,
    output sptw_pkg::t_q30   o_x,
    output sptw_pkg::t_q30   o_x2,
    output sptw_pkg::t_oct   o_oct,
    output sptw_pkg::t_range o_range
);
    import sptw_pkg::*;

    logic [4:0] r_valid;

    t_angle r1_prod;
    t_range r1_range;
    t_angle r2_ang;
    t_range r2_range;
    t_q30   r3_r;
    t_oct   r3_oct;
    t_range r3_range;
    t_q30   r4_x;
    t_oct   r4_oct;
    t_range r4_range;
    t_q30   r5_x;
    t_q30   r5_x2;
    t_oct   r5_oct;
    t_range r5_range;

    t_angle      n_prod;
    t_angle      n_ang;
    t_q30        n_r;
    t_oct        n_oct;
    logic [60:0] n_xprod;
    logic [59:0] n_sq;

    always_comb begin
        n_prod = i_step_angle * t_angle'(i_beam_index & IDX_MASK);
        n_ang  = (r1_prod + i_start_angle + i_mount_rotation) & ANGLE_KEEP;

        // Fold the angle into the first octant of its quadrant.
        n_oct.quad     = r2_ang[31:30];
        n_oct.low_half = (r2_ang[29:0] < OCT_HALF);
        if (n_oct.low_half) begin
            n_r = r2_ang[29:0];
        end else begin
            n_r = t_q30'(Q30_ONE - {1'b0, r2_ang[29:0]});
        end

        n_xprod = 61'(r3_r) * 61'(PI4_Q31);
        n_sq    = 60'(r4_x) * 60'(r4_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod  <= n_prod;
            r1_range <= i_range_mm;
            r2_ang   <= n_ang;
            r2_range <= r1_range;
            r3_r     <= n_r;
            r3_oct   <= n_oct;
            r3_range <= r2_range;
            r4_x     <= n_xprod[59:30];
            r4_oct   <= r3_oct;
            r4_range <= r3_range;
            r5_x     <= r4_x;
            r5_x2    <= n_sq[59:30];
            r5_oct   <= r4_oct;
            r5_range <= r4_range;
        end
    end

    assign o_valid = r_valid[4];
    assign o_x     = r5_x;
    assign o_x2    = r5_x2;
    assign o_oct   = r5_oct;
    assign o_range = r5_range;

endmodule

`default_nettype wire

@@ rtl/core/sptw_horner_step.sv @@
`default_nettype none

// One series step: t_out = 1 - floor(floor(x2 * t) / k), all in Q30.
// The division by k uses a truncated reciprocal, which is low by at most one,
// and a remainder check fixes it.
module sptw_horner_step (
    input  logic            i_clk,
    input  logic            i_en,
    input  sptw_pkg::t_coef i_k,
    input  sptw_pkg::t_q30  i_recip,
    input  sptw_pkg::t_q30  i_x2,
    input  sptw_pkg::t_q30e i_t,
    output sptw_pkg::t_q30e o_t
);
    import sptw_pkg::*;

    t_q30  ra_m;
    t_q30  rb_m;
    t_q30  rb_qp;
    t_q30  rc_m;
    t_q30  rc_qp;
    t_q30  rc_qk;
    t_q30e rd_t;

    logic [60:0] n_mprod;
    logic [59:0] n_qprod;
    logic [37:0] n_kprod;
    t_q30        n_rem;
    t_q30        n_q;

    always_comb begin
        n_mprod = 61'(i_x2) * 61'(i_t);
        n_qprod = 60'(ra_m) * 60'(i_recip);
        n_kprod = 38'(rb_qp) * 38'(i_k);
        n_rem   = rc_m - rc_qk;
        n_q     = rc_qp + t_q30'(n_rem >= t_q30'(i_k));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_m  <= n_mprod[59:30];
            rb_m  <= ra_m;
            rb_qp <= n_qprod[59:30];
            rc_m  <= rb_m;
            rc_qp <= rb_qp;
            rc_qk <= n_kprod[29:0];
            rd_t  <= Q30_ONE - {1'b0, n_q};
        end
    end

    assign o_t = rd_t;

endmodule

`default_nettype wire

@@ rtl/core/sptw_trig.sv @@
`default_nettype none

module sptw_trig (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  sptw_pkg::t_q30   i_x,
    input  sptw_pkg::t_q30   i_x2,
    input  sptw_pkg::t_oct   i_oct,
    input  sptw_pkg::t_range i_range,
    output logic             o_valid,
    output sptw_pkg::t_trig  o_trig,
    output sptw_pkg::t_range o_range
);
    import sptw_pkg::*;

    localparam int SIN_LAT   = SIN_STEPS * STEP_LAT;
    localparam int CHAIN_LAT = COS_STEPS * STEP_LAT;
    localparam int LINE_D    = (COS_STEPS - 1) * STEP_LAT;
    localparam int SV_PAD    = CHAIN_LAT - SIN_LAT - 1;
    localparam t_q30e ROUND_Q30 = t_q30e'(31'd1 << (29 - TRIG_FRAC_BITS));

    function automatic t_mag to_frac(input t_q30e v);
        t_q30e sum;
        sum = v + ROUND_Q30;
        return sum[30 -: TRIG_FRAC_BITS + 1];
    endfunction

    t_q30   r_x2_line  [1:LINE_D];
    t_q30   r_x_line   [1:SIN_LAT];
    t_q30e  r_sv_pad   [1:SV_PAD];
    logic   r_vld_line [1:CHAIN_LAT];
    t_oct   r_oct_line [1:CHAIN_LAT];
    t_range r_rng_line [1:CHAIN_LAT];
    t_q30e  r_sv;
    logic   r_valid;
    t_trig  r_trig;
    t_range r_range;

    t_q30  w_x2_tap [0:COS_STEPS-1];
    t_q30e w_sin_t  [0:SIN_STEPS];
    t_q30e w_cos_t  [0:COS_STEPS];

    assign w_sin_t[0] = Q30_ONE;
    assign w_cos_t[0] = Q30_ONE;

    // Each step needs x2 at the moment its partial result enters it.
    for (genvar g = 0; g < COS_STEPS; g++) begin : g_tap
        if (g == 0) begin : g_first
            assign w_x2_tap[g] = i_x2;
        end else begin : g_rest
            assign w_x2_tap[g] = r_x2_line[g * STEP_LAT];
        end
    end

    for (genvar g = 0; g < SIN_STEPS; g++) begin : g_sin
        localparam t_q30 RECIP = t_q30'(Q30_ONE / t_q30e'(SIN_K[g]));
        sptw_horner_step u_step (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_k     (SIN_K[g]),
            .i_recip (RECIP),
            .i_x2    (w_x2_tap[g]),
            .i_t     (w_sin_t[g]),
            .o_t     (w_sin_t[g + 1])
        );
    end

    for (genvar g = 0; g < COS_STEPS; g++) begin : g_cos
        localparam t_q30 RECIP = t_q30'(Q30_ONE / t_q30e'(COS_K[g]));
        sptw_horner_step u_step (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_k     (COS_K[g]),
            .i_recip (RECIP),
            .i_x2    (w_x2_tap[g]),
            .i_t     (w_cos_t[g]),
            .o_t     (w_cos_t[g + 1])
        );
    end

    logic [60:0] n_sv_prod;
    t_mag        n_sv_frac;
    t_mag        n_cv_frac;
    t_mag        n_s0;
    t_mag        n_c0;
    t_oct        w_oct;
    t_trig       n_trig;

    always_comb begin
        n_sv_prod = 61'(r_x_line[SIN_LAT]) * 61'(w_sin_t[SIN_STEPS]);
        w_oct     = r_oct_line[CHAIN_LAT];
        n_sv_frac = to_frac(r_sv_pad[SV_PAD]);
        n_cv_frac = to_frac(w_cos_t[COS_STEPS]);
        // In the upper half of an octant pair sine and cosine trade places.
        n_s0 = w_oct.low_half ? n_sv_frac : n_cv_frac;
        n_c0 = w_oct.low_half ? n_cv_frac : n_sv_frac;
        n_trig.sin_mag = w_oct.quad[0] ? n_c0 : n_s0;
        n_trig.sin_neg = w_oct.quad[1];
        n_trig.cos_mag = w_oct.quad[0] ? n_s0 : n_c0;
        n_trig.cos_neg = w_oct.quad[1] ^ w_oct.quad[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 1; d <= CHAIN_LAT; d++) begin
                r_vld_line[d] <= 1'b0;
            end
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_vld_line[1] <= i_valid;
            for (int d = 2; d <= CHAIN_LAT; d++) begin
                r_vld_line[d] <= r_vld_line[d - 1];
            end
            r_valid <= r_vld_line[CHAIN_LAT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x2_line[1] <= i_x2;
            for (int d = 2; d <= LINE_D; d++) begin
                r_x2_line[d] <= r_x2_line[d - 1];
            end
            r_x_line[1] <= i_x;
            for (int d = 2; d <= SIN_LAT; d++) begin
                r_x_line[d] <= r_x_line[d - 1];
            end
            r_oct_line[1] <= i_oct;
            r_rng_line[1] <= i_range;
            for (int d = 2; d <= CHAIN_LAT; d++) begin
                r_oct_line[d] <= r_oct_line[d - 1];
                r_rng_line[d] <= r_rng_line[d - 1];
            end
            r_sv        <= t_q30e'(n_sv_prod[60:30]);
            r_sv_pad[1] <= r_sv;
            for (int d = 2; d <= SV_PAD; d++) begin
                r_sv_pad[d] <= r_sv_pad[d - 1];
            end
            r_trig  <= n_trig;
            r_range <= r_rng_line[CHAIN_LAT];
        end
    end

    assign o_valid = r_valid;
    assign o_trig  = r_trig;
    assign o_range = r_range;

endmodule

`default_nettype wire

@@ rtl/core/sptw_scale.sv @@
`default_nettype none

module sptw_scale (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  sptw_pkg::t_trig  i_trig,
    input  sptw_pkg::t_range i_range,
    input  sptw_pkg::t_off   i_off_x,
    input  sptw_pkg::t_off   i_off_y,
    output logic             o_valid,
    output sptw_pkg::t_coord o_x_mm,
    output sptw_pkg::t_coord o_y_mm
);
    import sptw_pkg::*;

    localparam int PROD_W = RANGE_W + TRIG_FRAC_BITS + 1;
    localparam int SUM_W  = OUT_W + 1;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (TRIG_FRAC_BITS - 1);

    logic [2:0]        r_valid;
    logic [PROD_W-1:0] r1_prod_x;
    logic [PROD_W-1:0] r1_prod_y;
    logic              r1_neg_x;
    logic              r1_neg_y;
    t_range            r2_p_x;
    t_range            r2_p_y;
    logic              r2_neg_x;
    logic              r2_neg_y;
    t_coord            r3_x;
    t_coord            r3_y;

    logic [PROD_W-1:0]  n_sum_x;
    logic [PROD_W-1:0]  n_sum_y;
    logic signed [SUM_W-1:0] n_x;
    logic signed [SUM_W-1:0] n_y;

    always_comb begin
        // Magnitude is rounded half up, so ties go away from zero once signed.
        n_sum_x = r1_prod_x + HALF;
        n_sum_y = r1_prod_y + HALF;
        if (r2_neg_x) begin
            n_x = SUM_W'(i_off_x) - $signed(SUM_W'(r2_p_x));
        end else begin
            n_x = SUM_W'(i_off_x) + $signed(SUM_W'(r2_p_x));
        end
        if (r2_neg_y) begin
            n_y = SUM_W'(i_off_y) - $signed(SUM_W'(r2_p_y));
        end else begin
            n_y = SUM_W'(i_off_y) + $signed(SUM_W'(r2_p_y));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod_x <= PROD_W'(i_range) * PROD_W'(i_trig.cos_mag);
            r1_prod_y <= PROD_W'(i_range) * PROD_W'(i_trig.sin_mag);
            r1_neg_x  <= i_trig.cos_neg;
            r1_neg_y  <= i_trig.sin_neg;
            r2_p_x    <= n_sum_x[TRIG_FRAC_BITS +: RANGE_W];
            r2_p_y    <= n_sum_y[TRIG_FRAC_BITS +: RANGE_W];
            r2_neg_x  <= r1_neg_x;
            r2_neg_y  <= r1_neg_y;
            r3_x      <= t_coord'(n_x[OUT_W-1:0]);
            r3_y      <= t_coord'(n_y[OUT_W-1:0]);
        end
    end

    assign o_valid = r_valid[2];
    assign o_x_mm  = r3_x;
    assign o_y_mm  = r3_y;

endmodule

`default_nettype wire

@@ rtl/core/scan_point_to_world_xy.sv @@
`default_nettype none

// Channel   Direction  Handshake           Payload
// -------   ---------  ------------------  ------------------------------
// input     in         i_valid / o_stall   i_beam_index, i_range_mm
// output    out        o_valid / i_stall   o_x_mm, o_y_mm
// config    in         i_cfg_wen           i_cfg_idx, i_cfg_wdata
//
// One point per cycle while the output is not stalled; a point passes through
// 5 angle stages, 24 series stages plus one rounding stage and 3 scaling
// stages. The longer cosine series chain sets the depth.
// Reset clears the valid bits, the skid flag and the configuration registers
// to zero; the data registers of the pipeline are not reset.
// A stall of a valid output freezes the whole pipeline; one skid slot at the input
// takes the transfer of that cycle, and o_stall is the full flag of that slot.
module scan_point_to_world_xy (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sptw_pkg::t_index    i_beam_index,
    input  sptw_pkg::t_range    i_range_mm,
    output logic                o_valid,
    input  logic                i_stall,
    output sptw_pkg::t_coord    o_x_mm,
    output sptw_pkg::t_coord    o_y_mm,
    input  logic                i_cfg_wen,
    input  sptw_pkg::t_cfg_idx  i_cfg_idx,
    input  sptw_pkg::t_cfg_data i_cfg_wdata
);
    import sptw_pkg::*;

    t_angle r_step_angle;
    t_angle r_start_angle;
    t_angle r_mount_rotation;
    t_off   r_off_x;
    t_off   r_off_y;

    logic   r_skid_valid;
    t_index r_skid_idx;
    t_range r_skid_range;

    logic   w_en;
    logic   w_in_xfer;
    logic   w_feed_valid;
    t_index w_feed_idx;
    t_range w_feed_range;

    logic   w_a_valid;
    t_q30   w_a_x;
    t_q30   w_a_x2;
    t_oct   w_a_oct;
    t_range w_a_range;
    logic   w_t_valid;
    t_trig  w_t_trig;
    t_range w_t_range;

    assign w_en      = !(o_valid && i_stall);
    assign w_in_xfer = i_valid && !r_skid_valid;
    assign o_stall   = r_skid_valid;

    assign w_feed_valid = r_skid_valid || i_valid;
    assign w_feed_idx   = r_skid_valid ? r_skid_idx : i_beam_index;
    assign w_feed_range = r_skid_valid ? r_skid_range : i_range_mm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_angle     <= '0;
            r_start_angle    <= '0;
            r_mount_rotation <= '0;
            r_off_x          <= '0;
            r_off_y          <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_STEP_ANGLE:     r_step_angle     <= i_cfg_wdata;
                CFG_START_ANGLE:    r_start_angle    <= i_cfg_wdata;
                CFG_MOUNT_ROTATION: r_mount_rotation <= i_cfg_wdata;
                CFG_MOUNT_OFFSET_X: r_off_x <= t_off'(i_cfg_wdata[OFF_W-1:0]);
                CFG_MOUNT_OFFSET_Y: r_off_y <= t_off'(i_cfg_wdata[OFF_W-1:0]);
                default: ;
            endcase
        end
    end

    // The skid slot fills only when a transfer meets a frozen pipeline, and
    // drains into the first stage as soon as the pipeline moves again.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            r_skid_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && w_in_xfer) begin
            r_skid_idx   <= i_beam_index;
            r_skid_range <= i_range_mm;
        end
    end

    sptw_angle u_angle (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_valid          (w_feed_valid),
        .i_beam_index     (w_feed_idx),
        .i_range_mm       (w_feed_range),
        .i_step_angle     (r_step_angle),
        .i_start_angle    (r_start_angle),
        .i_mount_rotation (r_mount_rotation),
        .o_valid          (w_a_valid),
        .o_x              (w_a_x),
        .o_x2             (w_a_x2),
        .o_oct            (w_a_oct),
        .o_range          (w_a_range)
    );

    sptw_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_a_valid),
        .i_x     (w_a_x),
        .i_x2    (w_a_x2),
        .i_oct   (w_a_oct),
        .i_range (w_a_range),
        .o_valid (w_t_valid),
        .o_trig  (w_t_trig),
        .o_range (w_t_range)
    );

    sptw_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_t_valid),
        .i_trig  (w_t_trig),
        .i_range (w_t_range),
        .i_off_x (r_off_x),
        .i_off_y (r_off_y),
        .o_valid (o_valid),
        .o_x_mm  (o_x_mm),
        .o_y_mm  (o_y_mm)
    );

`ifndef ASSERT_OFF
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> !r_skid_valid)
        else $error("skid slot still full after the pipeline advanced");

    a_skid_catches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && w_in_xfer) |=> r_skid_valid)
        else $error("transfer into a frozen pipeline was not captured");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !w_en) |=>
            (r_skid_valid && $stable(r_skid_idx) && $stable(r_skid_range)))
        else $error("skid slot changed while the pipeline was frozen");
`endif

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import sptw_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TRIG_F = sptw_pkg::TRIG_FRAC_BITS;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned QUARTER_PI_Q31 = 64'd1686629713;
    localparam longint unsigned OCTANT = 64'h2000_0000;
    localparam t_index IDX_KEEP = t_index'((64'd1 << sptw_pkg::INDEX_BITS) - 64'd1);
    localparam t_angle ANG_KEEP = ~t_angle'((64'd1 << (32 - sptw_pkg::ANGLE_BITS)) - 64'd1);
    // Horner divisors, first step in the lowest byte.
    localparam logic [39:0] SIN_DIV = {8'd6, 8'd20, 8'd42, 8'd72, 8'd110};
    localparam logic [47:0] COS_DIV = {8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};

    typedef struct packed {
        t_index beam;
        t_range rng_mm;
    } scan_sample_t;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } map_xy_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_index     i_beam_index = '0;
    t_range     i_range_mm = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_coord     o_x_mm;
    t_coord     o_y_mm;
    logic       i_cfg_wen = 1'b0;
    t_cfg_idx   i_cfg_idx = CFG_STEP_ANGLE;
    t_cfg_data  i_cfg_wdata = '0;

    // Register copy used for prediction.
    t_angle step_ang = '0;
    t_angle start_ang = '0;
    t_angle mount_rot = '0;
    t_off   off_x = '0;
    t_off   off_y = '0;

    scan_sample_t sample_q[$];
    map_xy_t      expected_xy_q[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int fail_count = 0;
    int idle_cycles = 0;
    bit sample_taken = 1'b0;
    bit point_taken = 1'b0;

    scan_point_to_world_xy dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_beam_index(i_beam_index),
        .i_range_mm  (i_range_mm),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_x_mm      (o_x_mm),
        .o_y_mm      (o_y_mm),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint unsigned series_q30(longint unsigned x2, bit cos_series);
        longint unsigned t;
        longint unsigned k;
        int steps;
        t = ONE_Q30;
        steps = cos_series ? 6 : 5;
        for (int i = 0; i < steps; i++) begin
            k = cos_series ? longint'(COS_DIV[8*i +: 8]) : longint'(SIN_DIV[8*i +: 8]);
            t = ONE_Q30 - ((x2 * t) >> 30) / k;
        end
        return t;
    endfunction

    function automatic longint q30_to_trig(longint unsigned v);
        return longint'((v + (64'd1 << (29 - TRIG_F))) >> (30 - TRIG_F));
    endfunction

    // Magnitude rounded half up, sign applied afterwards.
    function automatic longint scale_mm(t_range rng_mm, longint trig);
        longint unsigned mag;
        longint unsigned p;
        mag = (trig < 0) ? longint'(-trig) : longint'(trig);
        p = (longint'(rng_mm) * mag + (64'd1 << (TRIG_F - 1))) >> TRIG_F;
        return (trig < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic map_xy_t project_point(t_index beam, t_range rng_mm);
        t_angle ang;
        longint unsigned b, r, x, x2, sv, cv;
        longint s0, c0, s, c;
        map_xy_t res;
        ang = (step_ang * t_angle'(beam & IDX_KEEP) + start_ang + mount_rot) & ANG_KEEP;
        b = longint'(ang[29:0]);
        r = (b < OCTANT) ? b : (64'h4000_0000 - b);
        x = (r * QUARTER_PI_Q31) >> 30;
        x2 = (x * x) >> 30;
        sv = (x * series_q30(x2, 1'b0)) >> 30;
        cv = series_q30(x2, 1'b1);
        // Past the octant midpoint the roles of sine and cosine swap.
        if (b < OCTANT) begin
            s0 = q30_to_trig(sv);
            c0 = q30_to_trig(cv);
        end else begin
            s0 = q30_to_trig(cv);
            c0 = q30_to_trig(sv);
        end
        case (ang[31:30])
            2'd0: begin s = s0;  c = c0;  end
            2'd1: begin s = c0;  c = -s0; end
            2'd2: begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0; end
        endcase
        res.x = t_coord'(longint'(off_x) + scale_mm(rng_mm, c));
        res.y = t_coord'(longint'(off_y) + scale_mm(rng_mm, s));
        return res;
    endfunction

    function automatic t_angle pick_angle();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return t_angle'($urandom_range(1 << 22));
            default: return t_angle'($urandom);
        endcase
    endfunction

    // Offset word: upper bits are random and must be ignored by the block.
    function automatic t_cfg_data pick_offset();
        t_cfg_data d;
        d = $urandom;
        case ($urandom_range(3))
            0: d[16:0] = 17'h1_0000;
            1: d[16:0] = 17'h0_FFFF;
            default: ;
        endcase
        return d;
    endfunction

    task automatic write_reg(t_cfg_idx idx, t_cfg_data data);
        @(negedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            CFG_STEP_ANGLE:     step_ang = data;
            CFG_START_ANGLE:    start_ang = data;
            CFG_MOUNT_ROTATION: mount_rot = data;
            CFG_MOUNT_OFFSET_X: off_x = t_off'(data[16:0]);
            CFG_MOUNT_OFFSET_Y: off_y = t_off'(data[16:0]);
            default: ;
        endcase
    endtask

    task automatic write_unused_regs();
        for (int k = CFG_MOUNT_OFFSET_Y + 1; k < (1 << CFG_IDX_W); k++) begin
            write_reg(t_cfg_idx'(k), $urandom);
        end
    endtask

    task automatic queue_sample(t_index beam, t_range rng_mm);
        scan_sample_t s;
        s.beam = beam;
        s.rng_mm = rng_mm;
        sample_q = {sample_q, s};
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin tx_idle_pct = 24; rx_idle_pct = 79; end
            1: begin tx_idle_pct = 79; rx_idle_pct = 24; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        endcase
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || i_valid || expected_xy_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin : drive_inputs
        scan_sample_t next_s;
        i_stall <= ($urandom_range(99) < rx_idle_pct);
        if (!i_valid || sample_taken) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_s = sample_q.pop_front();
                i_valid <= 1'b1;
                i_beam_index <= next_s.beam;
                i_range_mm <= next_s.rng_mm;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watch_ports
        map_xy_t want;
        sample_taken = i_rst_n && i_valid && !o_stall;
        point_taken = i_rst_n && o_valid && !i_stall;
        if (sample_taken) begin
            expected_xy_q = {expected_xy_q, project_point(i_beam_index, i_range_mm)};
        end
        if (point_taken) begin
            if (expected_xy_q.size() == 0) begin
                $error("unexpected point transfer: x_mm %0d, y_mm %0d", o_x_mm, o_y_mm);
                fail_count++;
            end else begin
                want = expected_xy_q.pop_front();
                if (o_x_mm !== want.x) begin
                    $error("x_mm mismatch: expected %0d, actual %0d", want.x, o_x_mm);
                    fail_count++;
                end
                if (o_y_mm !== want.y) begin
                    $error("y_mm mismatch: expected %0d, actual %0d", want.y, o_y_mm);
                    fail_count++;
                end
            end
        end
        if (!i_rst_n || sample_taken || point_taken) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All registers at their reset value: angle zero everywhere.
        set_idling(0);
        queue_sample(12'd0, 16'd0);
        queue_sample(12'hFFF, 16'hFFFF);
        queue_sample(12'h800, 16'h1234);
        drain();

        // Eighth-turn steps land exactly on every octant and quadrant boundary.
        set_idling(1);
        write_reg(CFG_STEP_ANGLE, 32'h2000_0000);
        for (int i = 0; i <= 8; i++) begin
            queue_sample(t_index'(i), 16'hFFFF);
        end
        queue_sample(12'hFFF, 16'hFFFF);
        queue_sample(12'd1, 16'd1);
        drain();

        // Every angle sum wraps; offsets at opposite extremes.
        set_idling(2);
        write_reg(CFG_STEP_ANGLE, '1);
        write_reg(CFG_START_ANGLE, '1);
        write_reg(CFG_MOUNT_ROTATION, '1);
        write_reg(CFG_MOUNT_OFFSET_X, 32'hFFFF_0000);
        write_reg(CFG_MOUNT_OFFSET_Y, 32'h5555_FFFF);
        write_unused_regs();
        queue_sample(12'd0, 16'hFFFF);
        queue_sample(12'hFFF, 16'hFFFF);
        queue_sample(12'h800, 16'hFFFF);
        queue_sample(12'd1, 16'd0);
        drain();

        write_reg(CFG_MOUNT_ROTATION, 32'h4000_0000);
        write_reg(CFG_MOUNT_OFFSET_X, 32'h0000_FFFF);
        write_reg(CFG_MOUNT_OFFSET_Y, 32'hAAAB_0000);
        queue_sample(12'd0, 16'hFFFF);
        queue_sample(12'd3000, 16'hFFFF);
        drain();

        for (int p = 0; p < 6; p++) begin
            set_idling(p / 2);
            write_reg(CFG_STEP_ANGLE, pick_angle());
            write_reg(CFG_START_ANGLE, pick_angle());
            write_reg(CFG_MOUNT_ROTATION, pick_angle());
            write_reg(CFG_MOUNT_OFFSET_X, pick_offset());
            write_reg(CFG_MOUNT_OFFSET_Y, pick_offset());
            write_unused_regs();
            repeat (300) begin
                case ($urandom_range(9))
                    0: queue_sample(t_index'($urandom), 16'd0);
                    1: queue_sample(t_index'($urandom), 16'hFFFF);
                    default: queue_sample(t_index'($urandom), t_range'($urandom));
                endcase
            end
            drain();
        end

        // Leave room for any stray point after the last expected one.
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
